[sv/rpn_stack_calculator_unit_macros.svh]
// Assertion macros shared by the checker of the RPN stack calculator.
`ifndef RPN_STACK_CALCULATOR_UNIT_MACROS_SVH
`define RPN_STACK_CALCULATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clock and idle during reset.
`define RPN_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and idle during reset.
`define RPN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/rpn_pkg.sv]
// Package of the RPN stack calculator: sizes, codes, types and saturation.
`timescale 1ns / 1ps

package rpn_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int VAL_W       = 32;
   localparam int CMD_W       = 4;
   localparam int STAT_W      = 3;
   localparam int CNT_OUT_W   = 5;
   localparam int SUM_W       = VAL_W + IDX_W + 1;
   localparam int FRAC_W      = 16;
   localparam int DIV_W       = VAL_W + FRAC_W;
   localparam int DSTEP_W     = $clog2(DIV_W + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH = 4'd0,
      CMD_PEEK = 4'd1,
      CMD_ADD  = 4'd2,
      CMD_SUB  = 4'd3,
      CMD_MUL  = 4'd4,
      CMD_DIV  = 4'd5,
      CMD_XCHG = 4'd6,
      CMD_SUM  = 4'd7,
      CMD_AVG  = 4'd8
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_ONE     = 3'd2,
      ST_DIVZERO = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_TOP_WAIT,
      S_P_WAIT,
      S_Q_WAIT,
      S_MUL,
      S_DIV_RUN,
      S_SUM_WALK,
      S_SUM_DONE,
      S_WRITE,
      S_SWAP2,
      S_RESP
   } state_type;

   typedef struct packed {
      logic                    start;
      logic signed [DIV_W-1:0] dividend;
      logic signed [VAL_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic             neg;
      logic [DIV_W-1:0] mag;
   } div_rsp_type;

   function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [VAL_W-1:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[VAL_W-1:0];
      end
      return r;
   endfunction

endpackage

[sv/rpn_stack_calculator_unit.sv]
// Top level of the RPN stack calculator: sequencer, datapath and stack memory.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_cmd, req_push_value
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_top_value, rsp_status, rsp_stack_count
//
// One command at a time; the stack lives in a RAM with a registered read port.
// Divide and average run the 48-step divider; average first sums the entries.
// Sum walks the N stored entries one read a cycle.
// Synchronous reset empties the stack at once; no clearing pass is needed.
// req_stall is high from acceptance until the result beat has been taken.
`timescale 1ns / 1ps

module rpn_stack_calculator_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rpn_pkg::CMD_W-1:0]           req_cmd,
   input  logic signed [rpn_pkg::VAL_W-1:0]    req_push_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rpn_pkg::VAL_W-1:0]    rsp_top_value,
   output logic [rpn_pkg::STAT_W-1:0]          rsp_status,
   output logic [rpn_pkg::CNT_OUT_W-1:0]       rsp_stack_count
);

   rpn_pkg::state_type                 state_ff, state_in;
   logic [rpn_pkg::CMD_W-1:0]          cmd_ff;
   logic signed [rpn_pkg::VAL_W-1:0]   val_ff;
   logic [rpn_pkg::CNT_W-1:0]          count_ff;
   logic [rpn_pkg::CNT_W-1:0]          idx_ff;
   logic signed [rpn_pkg::VAL_W-1:0]   top_ff;
   logic signed [rpn_pkg::VAL_W-1:0]   p_ff;
   logic signed [rpn_pkg::VAL_W-1:0]   q_ff;
   logic signed [rpn_pkg::VAL_W-1:0]   result_ff;
   logic signed [63:0]                 prod_ff;
   logic signed [rpn_pkg::SUM_W-1:0]   acc_ff;
   logic [rpn_pkg::STAT_W-1:0]         status_ff;
   logic                               push_ff;

   logic                               mem_we;
   logic [rpn_pkg::IDX_W-1:0]          mem_waddr;
   logic [rpn_pkg::VAL_W-1:0]          mem_wdata;
   logic [rpn_pkg::IDX_W-1:0]          mem_raddr;
   logic [rpn_pkg::VAL_W-1:0]          mem_rdata;
   logic signed [rpn_pkg::VAL_W-1:0]   rdata_s;

   rpn_pkg::div_req_type               div_req;
   rpn_pkg::div_rsp_type               div_rsp;

   logic                               full, empty, one_only, p_zero;
   logic [rpn_pkg::IDX_W-1:0]          cnt_idx, cnt_m1, cnt_m2;
   logic signed [63:0]                 prod_adj;
   logic signed [rpn_pkg::VAL_W-1:0]   mul_res;
   logic signed [rpn_pkg::VAL_W-1:0]   div_res;

   assign rdata_s  = $signed(mem_rdata);
   assign full     = count_ff >= rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH);
   assign empty    = count_ff == '0;
   assign one_only = count_ff < rpn_pkg::CNT_W'(2);
   assign p_zero   = mem_rdata == '0;
   assign cnt_idx  = count_ff[rpn_pkg::IDX_W-1:0];
   assign cnt_m1   = rpn_pkg::IDX_W'(count_ff - rpn_pkg::CNT_W'(1));
   assign cnt_m2   = rpn_pkg::IDX_W'(count_ff - rpn_pkg::CNT_W'(2));

   // Product scaled back by 2^16, rounding toward zero.
   assign prod_adj = prod_ff[63] ? prod_ff + 64'sd65535 : prod_ff;
   assign mul_res  = rpn_pkg::sat32(prod_adj >>> rpn_pkg::FRAC_W);

   always_comb begin
      if (div_rsp.neg) begin
         div_res = (div_rsp.mag > rpn_pkg::DIV_W'(64'd2147483648)) ? 32'sh80000000
                   : $signed(~div_rsp.mag[rpn_pkg::VAL_W-1:0] + 32'd1);
      end else begin
         div_res = (div_rsp.mag > rpn_pkg::DIV_W'(64'd2147483647)) ? 32'sh7FFFFFFF
                   : $signed(div_rsp.mag[rpn_pkg::VAL_W-1:0]);
      end
   end

   rpn_ram #(
      .WIDTH (rpn_pkg::VAL_W),
      .DEPTH (rpn_pkg::STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   rpn_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rpn_pkg::S_IDLE: begin
            if (req_valid) state_in = rpn_pkg::S_DECODE;
         end
         rpn_pkg::S_DECODE: begin
            case (cmd_ff) inside
               rpn_pkg::CMD_PUSH: begin
                  state_in = full ? rpn_pkg::S_TOP_WAIT : rpn_pkg::S_RESP;
               end
               rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL,
               rpn_pkg::CMD_DIV, rpn_pkg::CMD_XCHG: begin
                  state_in = empty ? rpn_pkg::S_RESP : rpn_pkg::S_P_WAIT;
               end
               rpn_pkg::CMD_SUM, rpn_pkg::CMD_AVG: begin
                  if (full) state_in = rpn_pkg::S_TOP_WAIT;
                  else if (!empty) state_in = rpn_pkg::S_SUM_WALK;
                  else if (cmd_ff == rpn_pkg::CMD_AVG) state_in = rpn_pkg::S_RESP;
                  else state_in = rpn_pkg::S_SUM_DONE;
               end
               default: begin
                  state_in = empty ? rpn_pkg::S_RESP : rpn_pkg::S_TOP_WAIT;
               end
            endcase
         end
         rpn_pkg::S_TOP_WAIT: state_in = rpn_pkg::S_RESP;
         rpn_pkg::S_P_WAIT: begin
            if ((cmd_ff == rpn_pkg::CMD_DIV && p_zero) || one_only) begin
               state_in = rpn_pkg::S_RESP;
            end else begin
               state_in = rpn_pkg::S_Q_WAIT;
            end
         end
         rpn_pkg::S_Q_WAIT: begin
            case (cmd_ff)
               rpn_pkg::CMD_XCHG: state_in = rpn_pkg::S_SWAP2;
               rpn_pkg::CMD_MUL:  state_in = rpn_pkg::S_MUL;
               rpn_pkg::CMD_DIV:  state_in = rpn_pkg::S_DIV_RUN;
               default:           state_in = rpn_pkg::S_WRITE;
            endcase
         end
         rpn_pkg::S_MUL: state_in = rpn_pkg::S_WRITE;
         rpn_pkg::S_DIV_RUN: begin
            if (div_rsp.done) state_in = rpn_pkg::S_WRITE;
         end
         rpn_pkg::S_SUM_WALK: begin
            if (idx_ff == count_ff) state_in = rpn_pkg::S_SUM_DONE;
         end
         rpn_pkg::S_SUM_DONE: begin
            state_in = (cmd_ff == rpn_pkg::CMD_AVG) ? rpn_pkg::S_DIV_RUN : rpn_pkg::S_WRITE;
         end
         rpn_pkg::S_WRITE: state_in = rpn_pkg::S_RESP;
         rpn_pkg::S_SWAP2: state_in = rpn_pkg::S_RESP;
         rpn_pkg::S_RESP: begin
            if (!rsp_stall) state_in = rpn_pkg::S_IDLE;
         end
         default: state_in = rpn_pkg::S_IDLE;
      endcase
   end

   // Memory, divider and handshake controls.
   always_comb begin
      req_stall        = 1'b1;
      rsp_valid        = 1'b0;
      mem_we           = 1'b0;
      mem_waddr        = cnt_idx;
      mem_wdata        = val_ff;
      mem_raddr        = cnt_m1;
      div_req.start    = 1'b0;
      div_req.dividend = {rdata_s, {rpn_pkg::FRAC_W{1'b0}}};
      div_req.divisor  = p_ff;
      unique case (state_ff)
         rpn_pkg::S_IDLE: req_stall = 1'b0;
         rpn_pkg::S_DECODE: begin
            if (cmd_ff == rpn_pkg::CMD_PUSH && !full) mem_we = 1'b1;
            if ((cmd_ff == rpn_pkg::CMD_SUM || cmd_ff == rpn_pkg::CMD_AVG) && !full) begin
               mem_raddr = '0;
            end
         end
         rpn_pkg::S_P_WAIT: mem_raddr = cnt_m2;
         rpn_pkg::S_Q_WAIT: begin
            if (cmd_ff == rpn_pkg::CMD_XCHG) begin
               mem_we    = 1'b1;
               mem_waddr = cnt_m2;
               mem_wdata = p_ff;
            end
            if (cmd_ff == rpn_pkg::CMD_DIV) div_req.start = 1'b1;
         end
         rpn_pkg::S_SUM_WALK: mem_raddr = idx_ff[rpn_pkg::IDX_W-1:0];
         rpn_pkg::S_SUM_DONE: begin
            div_req.dividend = rpn_pkg::DIV_W'(acc_ff);
            div_req.divisor  = rpn_pkg::VAL_W'(count_ff);
            if (cmd_ff == rpn_pkg::CMD_AVG) div_req.start = 1'b1;
         end
         rpn_pkg::S_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = push_ff ? cnt_idx : cnt_m2;
            mem_wdata = result_ff;
         end
         rpn_pkg::S_SWAP2: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_m1;
            mem_wdata = q_ff;
         end
         rpn_pkg::S_RESP: rsp_valid = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpn_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == rpn_pkg::S_DECODE && cmd_ff == rpn_pkg::CMD_PUSH && !full) begin
            count_ff <= count_ff + rpn_pkg::CNT_W'(1);
         end else if (state_ff == rpn_pkg::S_WRITE) begin
            count_ff <= push_ff ? count_ff + rpn_pkg::CNT_W'(1)
                                : count_ff - rpn_pkg::CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         rpn_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd_ff <= req_cmd;
               val_ff <= req_push_value;
            end
         end
         rpn_pkg::S_DECODE: begin
            status_ff <= rpn_pkg::ST_OK;
            push_ff   <= cmd_ff == rpn_pkg::CMD_SUM || cmd_ff == rpn_pkg::CMD_AVG;
            acc_ff    <= '0;
            idx_ff    <= rpn_pkg::CNT_W'(1);
            case (cmd_ff) inside
               rpn_pkg::CMD_PUSH: begin
                  if (full) status_ff <= rpn_pkg::ST_FULL;
                  else top_ff <= val_ff;
               end
               rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL,
               rpn_pkg::CMD_DIV, rpn_pkg::CMD_XCHG: begin
                  if (empty) begin
                     status_ff <= rpn_pkg::ST_EMPTY;
                     top_ff    <= '0;
                  end
               end
               rpn_pkg::CMD_SUM, rpn_pkg::CMD_AVG: begin
                  if (full) begin
                     status_ff <= rpn_pkg::ST_FULL;
                  end else if (empty && cmd_ff == rpn_pkg::CMD_AVG) begin
                     status_ff <= rpn_pkg::ST_EMPTY;
                     top_ff    <= '0;
                  end
               end
               default: begin
                  if (empty) begin
                     top_ff <= '0;
                     if (cmd_ff == rpn_pkg::CMD_PEEK) status_ff <= rpn_pkg::ST_EMPTY;
                  end
               end
            endcase
         end
         rpn_pkg::S_TOP_WAIT: top_ff <= rdata_s;
         rpn_pkg::S_P_WAIT: begin
            p_ff   <= rdata_s;
            top_ff <= rdata_s;
            // A zero divisor is reported before the one-entry case.
            if (cmd_ff == rpn_pkg::CMD_DIV && p_zero) status_ff <= rpn_pkg::ST_DIVZERO;
            else if (one_only) status_ff <= rpn_pkg::ST_ONE;
         end
         rpn_pkg::S_Q_WAIT: begin
            q_ff <= rdata_s;
            case (cmd_ff)
               rpn_pkg::CMD_ADD: result_ff <= rpn_pkg::sat32(64'(rdata_s) + 64'(p_ff));
               rpn_pkg::CMD_SUB: result_ff <= rpn_pkg::sat32(64'(rdata_s) - 64'(p_ff));
               rpn_pkg::CMD_MUL: prod_ff   <= 64'(rdata_s) * 64'(p_ff);
               default: begin
               end
            endcase
         end
         rpn_pkg::S_MUL: result_ff <= mul_res;
         rpn_pkg::S_DIV_RUN: begin
            if (div_rsp.done) result_ff <= div_res;
         end
         rpn_pkg::S_SUM_WALK: begin
            acc_ff <= acc_ff + rpn_pkg::SUM_W'(rdata_s);
            idx_ff <= idx_ff + rpn_pkg::CNT_W'(1);
         end
         rpn_pkg::S_SUM_DONE: result_ff <= rpn_pkg::sat32(64'(acc_ff));
         rpn_pkg::S_WRITE: top_ff <= result_ff;
         rpn_pkg::S_SWAP2: top_ff <= q_ff;
         default: begin
         end
      endcase
   end

   assign rsp_top_value   = top_ff;
   assign rsp_status      = status_ff;
   assign rsp_stack_count = rpn_pkg::CNT_OUT_W'(count_ff);

endmodule

[sv/rpn_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/rpn_div.sv]
// Restoring divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module rpn_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rpn_pkg::div_req_type div_req,
   output rpn_pkg::div_rsp_type div_rsp
);

   logic                             busy_ff;
   logic                             done_ff;
   logic                             neg_ff;
   logic [rpn_pkg::DSTEP_W-1:0]      step_ff;
   logic [rpn_pkg::DIV_W-1:0]        num_ff;
   logic [rpn_pkg::DIV_W-1:0]        quo_ff;
   logic [rpn_pkg::VAL_W:0]          rem_ff;
   logic [rpn_pkg::VAL_W-1:0]        den_ff;
   logic [rpn_pkg::VAL_W:0]          rem_sh;
   logic                             fits;

   assign rem_sh = {rem_ff[rpn_pkg::VAL_W-1:0], num_ff[rpn_pkg::DIV_W-1]};
   assign fits   = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == rpn_pkg::DSTEP_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         neg_ff  <= div_req.dividend[rpn_pkg::DIV_W-1] ^ div_req.divisor[rpn_pkg::VAL_W-1];
         num_ff  <= div_req.dividend[rpn_pkg::DIV_W-1] ? -div_req.dividend : div_req.dividend;
         den_ff  <= div_req.divisor[rpn_pkg::VAL_W-1] ? -div_req.divisor : div_req.divisor;
         rem_ff  <= '0;
         quo_ff  <= '0;
         step_ff <= rpn_pkg::DSTEP_W'(rpn_pkg::DIV_W);
      end else if (busy_ff) begin
         num_ff  <= {num_ff[rpn_pkg::DIV_W-2:0], 1'b0};
         rem_ff  <= fits ? rem_sh - {1'b0, den_ff} : rem_sh;
         quo_ff  <= {quo_ff[rpn_pkg::DIV_W-2:0], fits};
         step_ff <= step_ff - rpn_pkg::DSTEP_W'(1);
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.neg  = neg_ff;
   assign div_rsp.mag  = quo_ff;

endmodule

[sv/rpn_chk.sv]
// Port-level checker for the RPN stack calculator and its bind.
`timescale 1ns / 1ps
`include "rpn_stack_calculator_unit_macros.svh"

module rpn_chk (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic signed [rpn_pkg::VAL_W-1:0] rsp_top_value,
   input logic [rpn_pkg::STAT_W-1:0]       rsp_status,
   input logic [rpn_pkg::CNT_OUT_W-1:0]    rsp_stack_count
);

   `RPN_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_top_value) && $stable(rsp_status) && $stable(rsp_stack_count), "result beat changed while stalled")
   `RPN_ASSERT_SAME(a_one_at_a_time, rsp_valid, req_stall, "command accepted while a result beat is pending")
   `RPN_ASSERT_SAME(a_depth_bound, rsp_valid, rsp_stack_count <= rpn_pkg::CNT_OUT_W'(rpn_pkg::STACK_DEPTH), "stack depth beyond capacity")
   `RPN_ASSERT_SAME(a_empty_top, rsp_valid && rsp_stack_count == '0, rsp_top_value == '0, "empty stack reports a non-zero top")
   `RPN_ASSERT_SAME(a_empty_status, rsp_valid && rsp_status == rpn_pkg::ST_EMPTY, rsp_stack_count == '0, "empty status with entries on the stack")

endmodule

bind rpn_stack_calculator_unit rpn_chk u_rpn_chk (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_top_value   (rsp_top_value),
   .rsp_status      (rsp_status),
   .rsp_stack_count (rsp_stack_count)
);

[sim/tb_rpn_stack_calculator_unit.sv]
// Self-checking testbench of the RPN stack calculator, with its own predictor of the stack.
`timescale 1ns / 1ps

module tb_rpn_stack_calculator_unit;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 120;

   typedef struct {
      logic signed [rpn_pkg::VAL_W-1:0]  top;
      rpn_pkg::status_type               status;
      logic [rpn_pkg::CNT_OUT_W-1:0]     depth;
   } calc_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [rpn_pkg::CMD_W-1:0]           req_cmd = '0;
   logic signed [rpn_pkg::VAL_W-1:0]    req_push_value = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [rpn_pkg::VAL_W-1:0]    rsp_top_value;
   logic [rpn_pkg::STAT_W-1:0]          rsp_status;
   logic [rpn_pkg::CNT_OUT_W-1:0]       rsp_stack_count;

   // Own copy of the stack, updated as each command beat is accepted.
   logic signed [rpn_pkg::VAL_W-1:0]    shadow_stack [rpn_pkg::STACK_DEPTH];
   int                                  shadow_depth = 0;
   calc_result_type                     pending_results [$];

   int                          error_count = 0;
   int                          cycle_count = 0;
   int                          cmds_sent = 0;
   int                          results_seen = 0;
   int                          send_idle_pct = 0;
   int                          recv_idle_pct = 0;
   int                          hold_cycles = 0;

   rpn_stack_calculator_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_top_value   (rsp_top_value),
      .rsp_status      (rsp_status),
      .rsp_stack_count (rsp_stack_count)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   // Receiver: random stalls, or a long hold-off while hold_cycles runs down.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic logic signed [rpn_pkg::VAL_W-1:0] clamp_q16(input longint v);
      logic signed [rpn_pkg::VAL_W-1:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[rpn_pkg::VAL_W-1:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      if (error_count <= 30) begin
         $display("Mismatch at cycle %0d: %s got %0d, expected %0d.", cycle_count, what, got,
                  want);
      end
   endtask

   // Applies one command to the shadow stack and queues the result it should give.
   task automatic predict_command(input logic [rpn_pkg::CMD_W-1:0] cmd,
                                  input logic signed [rpn_pkg::VAL_W-1:0] val);
      calc_result_type res;
      longint       p;
      longint       q;
      longint       total;
      logic signed [rpn_pkg::VAL_W-1:0] r;
      res.status = rpn_pkg::ST_OK;
      case (cmd)
         rpn_pkg::CMD_PUSH: begin
            if (shadow_depth >= rpn_pkg::STACK_DEPTH) begin
               res.status = rpn_pkg::ST_FULL;
            end else begin
               shadow_stack[shadow_depth] = val;
               shadow_depth++;
            end
         end
         rpn_pkg::CMD_PEEK: begin
            if (shadow_depth == 0) res.status = rpn_pkg::ST_EMPTY;
         end
         rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV,
         rpn_pkg::CMD_XCHG: begin
            if (shadow_depth == 0) begin
               res.status = rpn_pkg::ST_EMPTY;
            end else begin
               p = shadow_stack[shadow_depth-1];
               if (cmd == rpn_pkg::CMD_DIV && p == 0) begin
                  res.status = rpn_pkg::ST_DIVZERO;
               end else if (shadow_depth < 2) begin
                  res.status = rpn_pkg::ST_ONE;
               end else begin
                  q = shadow_stack[shadow_depth-2];
                  if (cmd == rpn_pkg::CMD_XCHG) begin
                     shadow_stack[shadow_depth-2] = p[rpn_pkg::VAL_W-1:0];
                     shadow_stack[shadow_depth-1] = q[rpn_pkg::VAL_W-1:0];
                  end else begin
                     case (cmd)
                        rpn_pkg::CMD_ADD: r = clamp_q16(q + p);
                        rpn_pkg::CMD_SUB: r = clamp_q16(q - p);
                        rpn_pkg::CMD_MUL: r = clamp_q16((q * p) / 65536);
                        default:          r = clamp_q16((q * 65536) / p);
                     endcase
                     shadow_depth--;
                     shadow_stack[shadow_depth-1] = r;
                  end
               end
            end
         end
         rpn_pkg::CMD_SUM, rpn_pkg::CMD_AVG: begin
            total = 0;
            for (int i = 0; i < shadow_depth; i++) total += shadow_stack[i];
            if (cmd == rpn_pkg::CMD_AVG && shadow_depth == 0) begin
               res.status = rpn_pkg::ST_EMPTY;
            end else begin
               r = (cmd == rpn_pkg::CMD_SUM) ? clamp_q16(total)
                                             : clamp_q16(total / shadow_depth);
               if (shadow_depth >= rpn_pkg::STACK_DEPTH) begin
                  res.status = rpn_pkg::ST_FULL;
               end else begin
                  shadow_stack[shadow_depth] = r;
                  shadow_depth++;
               end
            end
         end
         default: ;
      endcase
      res.top = (shadow_depth == 0) ? '0 : shadow_stack[shadow_depth-1];
      res.depth = shadow_depth[rpn_pkg::CNT_OUT_W-1:0];
      pending_results.push_back(res);
   endtask

   // Sends one command beat; the caller is at a rising edge.
   task automatic send_cmd(input logic [rpn_pkg::CMD_W-1:0] cmd,
                           input logic signed [rpn_pkg::VAL_W-1:0] val);
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_push_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_command(cmd, val);
      cmds_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_cmd <= 4'($urandom);
         req_push_value <= $urandom;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Lowers valid and waits until every result is back and the block has settled.
   task automatic drain_results;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      calc_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result beat, depth", rsp_stack_count, -1);
         end else begin
            want = pending_results.pop_front();
            if (rsp_top_value !== want.top) report_mismatch("top_value", rsp_top_value, want.top);
            if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
            if (rsp_stack_count !== want.depth) begin
               report_mismatch("stack_count", rsp_stack_count, want.depth);
            end
         end
      end
   end

   function automatic logic signed [rpn_pkg::VAL_W-1:0] pick_value;
      logic signed [rpn_pkg::VAL_W-1:0] v;
      case ($urandom_range(9))
         0: v = 32'sh7FFFFFFF;
         1: v = 32'sh80000000;
         2: v = '0;
         3, 4: v = $urandom;
         5: v = 32'($signed($urandom_range(65535))) - 32'sd32768;
         default: v = ($urandom_range(1) ? 32'sd1 : -32'sd1) * $signed({16'd0, 16'($urandom)})
                      + 32'($signed($urandom_range(131071))) - 32'sd65536;
      endcase
      return v;
   endfunction

   task automatic test_empty_and_single;
      send_cmd(rpn_pkg::CMD_PEEK, 32'sh12345678);
      send_cmd(rpn_pkg::CMD_ADD, '0);
      send_cmd(rpn_pkg::CMD_DIV, '0);
      send_cmd(rpn_pkg::CMD_XCHG, '0);
      send_cmd(rpn_pkg::CMD_AVG, '0);
      // An empty sum pushes zero, so the divide below sees a zero top.
      send_cmd(rpn_pkg::CMD_SUM, '0);
      send_cmd(rpn_pkg::CMD_DIV, '0);
      send_cmd(rpn_pkg::CMD_PEEK, '0);
      send_cmd(rpn_pkg::CMD_SUB, '0);
      send_cmd(rpn_pkg::CMD_XCHG, '0);
      send_cmd(rpn_pkg::CMD_MUL, '0);
      send_cmd(4'd9, 32'shFFFFFFFF);
      send_cmd(4'd15, '0);
      drain_results();
   endtask

   task automatic test_arithmetic_extremes;
      send_cmd(rpn_pkg::CMD_PUSH, 32'sh7FFFFFFF);
      send_cmd(rpn_pkg::CMD_PUSH, 32'sh7FFFFFFF);
      send_cmd(rpn_pkg::CMD_ADD, '0);
      send_cmd(rpn_pkg::CMD_PUSH, 32'sh80000000);
      send_cmd(rpn_pkg::CMD_SUB, '0);
      send_cmd(rpn_pkg::CMD_PUSH, 32'sh80000000);
      send_cmd(rpn_pkg::CMD_MUL, '0);
      send_cmd(rpn_pkg::CMD_PUSH, 32'sh00000001);
      send_cmd(rpn_pkg::CMD_DIV, '0);
      send_cmd(rpn_pkg::CMD_PUSH, -32'sd196608);
      send_cmd(rpn_pkg::CMD_XCHG, '0);
      send_cmd(rpn_pkg::CMD_DIV, '0);
      send_cmd(rpn_pkg::CMD_AVG, '0);
      drain_results();
   endtask

   task automatic test_full_stack;
      while (shadow_depth < rpn_pkg::STACK_DEPTH) send_cmd(rpn_pkg::CMD_PUSH, pick_value());
      send_cmd(rpn_pkg::CMD_PUSH, 32'sh5A5A5A5A);
      send_cmd(rpn_pkg::CMD_SUM, '0);
      send_cmd(rpn_pkg::CMD_AVG, '0);
      send_cmd(rpn_pkg::CMD_ADD, '0);
      send_cmd(rpn_pkg::CMD_AVG, '0);
      drain_results();
   endtask

   task automatic test_random_commands(input int n, input int send_pct, input int recv_pct);
      int k;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 4 && shadow_depth < 4) begin
            // A run of pushes takes the stack up to full.
            repeat (rpn_pkg::STACK_DEPTH - shadow_depth + 1) begin
               send_cmd(rpn_pkg::CMD_PUSH, pick_value());
            end
         end else if (k < 34) begin
            send_cmd(rpn_pkg::CMD_PUSH, pick_value());
         end else if (k < 96) begin
            send_cmd(4'($urandom_range(rpn_pkg::CMD_PEEK, rpn_pkg::CMD_AVG)), $urandom);
         end else begin
            send_cmd(4'($urandom_range(9, 15)), $urandom);
         end
      end
      drain_results();
   endtask

   task automatic test_long_receiver_hold;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 400;
      repeat (40) send_cmd(4'($urandom_range(rpn_pkg::CMD_PUSH, rpn_pkg::CMD_AVG)), pick_value());
      drain_results();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_single();
      test_arithmetic_extremes();
      test_full_stack();
      test_random_commands(380, 14, 63);
      test_random_commands(380, 63, 14);
      test_random_commands(380, 0, 0);
      test_long_receiver_hold();
      $display("Sent %0d commands and checked %0d results over every command, status and depth,",
               cmds_sent, results_seen);
      $display("with idling on both sides and a long receiver hold-off; %0d mismatches.",
               error_count);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/rpn_pkg.sv
sv/rpn_ram.sv
sv/rpn_div.sv
sv/rpn_stack_calculator_unit.sv
sv/rpn_chk.sv
sim/tb_rpn_stack_calculator_unit.sv
